@@ hw/rtl/key_intent_resolver_unit_defines.svh @@
// Assertion macros for the key intent resolver RTL.
`ifndef KEY_INTENT_RESOLVER_UNIT_DEFINES_SVH
`define KEY_INTENT_RESOLVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// The expression holds at every clock edge out of reset.
`define KIR_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("key intent resolver: invariant violated");
// When the condition holds, the consequence holds in the same cycle.
`define KIR_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key intent resolver: implication violated");
`else
`define KIR_ASSERT_ALWAYS(lbl, expr)
`define KIR_ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/kir_pkg.sv @@
package kir_pkg;

  typedef logic [16:0] prob_t;
  typedef prob_t [3:0] probs_t;

  // Key bit positions in a mask.
  localparam int unsigned KEY_FWD   = 0;
  localparam int unsigned KEY_LEFT  = 1;
  localparam int unsigned KEY_BACK  = 2;
  localparam int unsigned KEY_RIGHT = 3;

  localparam logic [16:0] ONE_FX  = 17'd65536;
  localparam logic [6:0]  PCT_MAX = 7'd100;

  typedef enum logic [2:0] {
    CFG_KEY_ON        = 3'd0,
    CFG_KEY_OFF       = 3'd1,
    CFG_STEER_THR     = 3'd2,
    CFG_STEER_MARGIN  = 3'd3,
    CFG_MAX_KEYS      = 3'd4,
    CFG_CONFIRM       = 3'd5,
    CFG_CONF_PCT      = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    LBL_NEUTRAL   = 3'd0,
    LBL_FWD       = 3'd1,
    LBL_LEFT      = 3'd2,
    LBL_BACK      = 3'd3,
    LBL_RIGHT     = 3'd4,
    LBL_FWD_LEFT  = 3'd5,
    LBL_FWD_RIGHT = 3'd6
  } label_t;

  typedef struct packed {
    logic [16:0] key_on_threshold;
    logic [16:0] key_off_threshold;
    logic [16:0] combo_steer_threshold;
    logic [16:0] combo_steer_margin;
    logic [2:0]  max_active_keys;
    logic [3:0]  confirm_frames;
    logic [6:0]  confidence_threshold_percent;
  } cfg_t;

  // floor(p * 100 / 65536), saturated at 100.
  function automatic logic [6:0] to_percent(input logic [16:0] p);
    logic [23:0] prod;
    prod = {7'd0, p} * 24'd100;
    if (prod[23:16] > {1'b0, PCT_MAX}) begin
      return PCT_MAX;
    end
    return prod[22:16];
  endfunction

  function automatic label_t label_of(input logic [3:0] m);
    if (m[KEY_FWD] && m[KEY_LEFT]) return LBL_FWD_LEFT;
    if (m[KEY_FWD] && m[KEY_RIGHT]) return LBL_FWD_RIGHT;
    if (m[KEY_FWD]) return LBL_FWD;
    if (m[KEY_LEFT]) return LBL_LEFT;
    if (m[KEY_BACK]) return LBL_BACK;
    if (m[KEY_RIGHT]) return LBL_RIGHT;
    return LBL_NEUTRAL;
  endfunction

endpackage

@@ hw/rtl/key_intent_resolver_unit.sv @@
// Throughput: one item per cycle unless out_stall holds the pipeline.
// Each accepted item passes the input register, the decision logic and
// the result register, which form a two-stage pipeline with stall.
// Reset (rst, synchronous): clears valids and the debounce state, and loads
// the default configuration.
`include "key_intent_resolver_unit_defines.svh"

module key_intent_resolver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [16:0] prob_forward,
  input  logic [16:0] prob_left,
  input  logic [16:0] prob_back,
  input  logic [16:0] prob_right,
  input  logic        calibrated,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  key_set,
  output logic [2:0]  intent_label,
  output logic [6:0]  conf_percent,
  output logic [6:0]  forward_percent,
  output logic [6:0]  left_percent,
  output logic [6:0]  back_percent,
  output logic [6:0]  right_percent,
  output logic        confident,
  output logic        calibrated_flag
);

  kir_pkg::cfg_t   cfg;
  logic            s1_valid;
  kir_pkg::probs_t s1_probs;
  logic            s1_cal;
  logic            advance;

  logic [3:0] active_mask;
  logic [3:0] pending_mask;
  logic [3:0] pending_count;
  logic [3:0] active_mask_next;
  logic [3:0] pending_mask_next;
  logic [3:0] pending_count_next;
  logic [3:0] count_inc;
  logic [3:0] raw_mask;

  logic [16:0] mx;
  logic [16:0] mn;
  logic [16:0] conf_p;
  logic [6:0]  conf_pct;
  logic [6:0]  thr_pct;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_on_threshold             <= 17'd39322;
      cfg.key_off_threshold            <= 17'd26214;
      cfg.combo_steer_threshold        <= 17'd32768;
      cfg.combo_steer_margin           <= 17'd6554;
      cfg.max_active_keys              <= 3'd2;
      cfg.confirm_frames               <= 4'd2;
      cfg.confidence_threshold_percent <= 7'd50;
    end else if (cfg_write) begin
      case (kir_pkg::cfg_index_t'(cfg_index))
        kir_pkg::CFG_KEY_ON:       cfg.key_on_threshold <= cfg_data;
        kir_pkg::CFG_KEY_OFF:      cfg.key_off_threshold <= cfg_data;
        kir_pkg::CFG_STEER_THR:    cfg.combo_steer_threshold <= cfg_data;
        kir_pkg::CFG_STEER_MARGIN: cfg.combo_steer_margin <= cfg_data;
        kir_pkg::CFG_MAX_KEYS:     cfg.max_active_keys <= cfg_data[2:0];
        kir_pkg::CFG_CONFIRM:      cfg.confirm_frames <= cfg_data[3:0];
        kir_pkg::CFG_CONF_PCT:     cfg.confidence_threshold_percent <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_probs[kir_pkg::KEY_FWD]   <= prob_forward;
      s1_probs[kir_pkg::KEY_LEFT]  <= prob_left;
      s1_probs[kir_pkg::KEY_BACK]  <= prob_back;
      s1_probs[kir_pkg::KEY_RIGHT] <= prob_right;
      s1_cal                       <= calibrated;
    end
  end

  kir_resolve u_resolve (
    .probs       (s1_probs),
    .active_mask (active_mask),
    .cfg         (cfg),
    .raw_mask    (raw_mask)
  );

  // Debounce: a new nonzero mask commits after confirm_frames items in a row.
  always_comb begin
    active_mask_next  = active_mask;
    pending_mask_next = pending_mask;
    pending_count_next = pending_count;
    count_inc = 4'd1;
    if (raw_mask == 4'd0 || raw_mask == active_mask) begin
      active_mask_next   = raw_mask;
      pending_mask_next  = 4'd0;
      pending_count_next = 4'd0;
    end else begin
      if (raw_mask == pending_mask) begin
        count_inc = pending_count + 4'd1;
      end else begin
        pending_mask_next = raw_mask;
      end
      if (count_inc >= cfg.confirm_frames) begin
        active_mask_next   = raw_mask;
        pending_mask_next  = 4'd0;
        pending_count_next = 4'd0;
      end else begin
        pending_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask   <= 4'd0;
      pending_mask  <= 4'd0;
      pending_count <= 4'd0;
    end else if (advance) begin
      active_mask   <= active_mask_next;
      pending_mask  <= pending_mask_next;
      pending_count <= pending_count_next;
    end
  end

  // Confidence comes from the committed mask, not the raw one.
  always_comb begin
    mx = s1_probs[0];
    mn = kir_pkg::ONE_FX;
    for (int i = 0; i < 4; i++) begin
      if (s1_probs[i] > mx) begin
        mx = s1_probs[i];
      end
      if (active_mask_next[i] && s1_probs[i] < mn) begin
        mn = s1_probs[i];
      end
    end
    if (active_mask_next == 4'd0) begin
      conf_p = (mx >= kir_pkg::ONE_FX) ? 17'd0 : kir_pkg::ONE_FX - mx;
    end else begin
      conf_p = mn;
    end
    conf_pct = kir_pkg::to_percent(conf_p);
    thr_pct  = (cfg.confidence_threshold_percent > kir_pkg::PCT_MAX) ?
               kir_pkg::PCT_MAX : cfg.confidence_threshold_percent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_set            <= active_mask_next;
      intent_label       <= kir_pkg::label_of(active_mask_next);
      conf_percent       <= conf_pct;
      forward_percent    <= kir_pkg::to_percent(s1_probs[kir_pkg::KEY_FWD]);
      left_percent       <= kir_pkg::to_percent(s1_probs[kir_pkg::KEY_LEFT]);
      back_percent       <= kir_pkg::to_percent(s1_probs[kir_pkg::KEY_BACK]);
      right_percent      <= kir_pkg::to_percent(s1_probs[kir_pkg::KEY_RIGHT]);
      confident          <= (conf_pct >= thr_pct);
      calibrated_flag    <= s1_cal;
    end
  end

  `KIR_ASSERT_IMPLIES(a_no_opposite_keys, out_valid,
    !(key_set[kir_pkg::KEY_FWD] && key_set[kir_pkg::KEY_BACK]) &&
    !(key_set[kir_pkg::KEY_LEFT] && key_set[kir_pkg::KEY_RIGHT]))
  `KIR_ASSERT_IMPLIES(a_two_keys_max, out_valid, $countones(key_set) <= 2)
  `KIR_ASSERT_ALWAYS(a_pending_consistent,
    ((pending_count == 4'd0) == (pending_mask == 4'd0)) &&
    ((pending_mask == 4'd0) || (pending_mask != active_mask)))

endmodule

@@ hw/rtl/kir_resolve.sv @@
module kir_resolve (
  input  kir_pkg::probs_t probs,
  input  logic [3:0]      active_mask,
  input  kir_pkg::cfg_t   cfg,
  output logic [3:0]      raw_mask
);

  logic [3:0]  cand_mask;
  logic [3:0]  mask;
  logic [16:0] thr;
  logic [16:0] left_thr;
  logic [16:0] right_thr;
  logic        left_ok;
  logic        right_ok;
  logic        limit_one;
  logic [16:0] steer_p;

  always_comb begin
    cand_mask = '0;
    for (int i = 0; i < 4; i++) begin
      thr = active_mask[i] ? cfg.key_off_threshold : cfg.key_on_threshold;
      cand_mask[i] = (probs[i] >= thr);
    end

    // Opposite keys: the stronger one stays, ties go to forward and left.
    if (cand_mask[kir_pkg::KEY_FWD] && cand_mask[kir_pkg::KEY_BACK]) begin
      if (probs[kir_pkg::KEY_FWD] >= probs[kir_pkg::KEY_BACK]) begin
        cand_mask[kir_pkg::KEY_BACK] = 1'b0;
      end else begin
        cand_mask[kir_pkg::KEY_FWD] = 1'b0;
      end
    end
    if (cand_mask[kir_pkg::KEY_LEFT] && cand_mask[kir_pkg::KEY_RIGHT]) begin
      if (probs[kir_pkg::KEY_LEFT] >= probs[kir_pkg::KEY_RIGHT]) begin
        cand_mask[kir_pkg::KEY_RIGHT] = 1'b0;
      end else begin
        cand_mask[kir_pkg::KEY_LEFT] = 1'b0;
      end
    end

    left_thr  = active_mask[kir_pkg::KEY_LEFT] ? cfg.key_off_threshold
                                               : cfg.combo_steer_threshold;
    right_thr = active_mask[kir_pkg::KEY_RIGHT] ? cfg.key_off_threshold
                                                : cfg.combo_steer_threshold;
    left_ok  = (probs[kir_pkg::KEY_LEFT] >= left_thr) &&
               ({1'b0, probs[kir_pkg::KEY_LEFT]} >=
                {1'b0, probs[kir_pkg::KEY_RIGHT]} + {1'b0, cfg.combo_steer_margin});
    right_ok = (probs[kir_pkg::KEY_RIGHT] >= right_thr) &&
               ({1'b0, probs[kir_pkg::KEY_RIGHT]} >=
                {1'b0, probs[kir_pkg::KEY_LEFT]} + {1'b0, cfg.combo_steer_margin});

    mask = cand_mask;
    if (cand_mask[kir_pkg::KEY_BACK]) begin
      mask = '0;
      mask[kir_pkg::KEY_BACK] = 1'b1;
    end else if (cand_mask[kir_pkg::KEY_FWD]) begin
      mask = '0;
      mask[kir_pkg::KEY_FWD] = 1'b1;
      if (left_ok) begin
        mask[kir_pkg::KEY_LEFT] = 1'b1;
      end else if (right_ok) begin
        mask[kir_pkg::KEY_RIGHT] = 1'b1;
      end
    end

    // At most forward plus one steer key can be set here, so pruning matters
    // only for a limit of one or zero: the weaker key goes, forward on a tie.
    limit_one = (cfg.max_active_keys <= 3'd1);
    steer_p = mask[kir_pkg::KEY_LEFT] ? probs[kir_pkg::KEY_LEFT]
                                      : probs[kir_pkg::KEY_RIGHT];
    if (limit_one && mask[kir_pkg::KEY_FWD] &&
        (mask[kir_pkg::KEY_LEFT] || mask[kir_pkg::KEY_RIGHT])) begin
      if (steer_p >= probs[kir_pkg::KEY_FWD]) begin
        mask[kir_pkg::KEY_FWD] = 1'b0;
      end else begin
        mask[kir_pkg::KEY_LEFT]  = 1'b0;
        mask[kir_pkg::KEY_RIGHT] = 1'b0;
      end
    end

    raw_mask = mask;
  end

endmodule
